FILE: rtl/wbih_pkg.sv
// wbih_pkg: shared types, constants and codes of the busy/idle hysteresis block
// used by every rtl file of the block; depends on nothing

package wbih_pkg;

   // payload and register widths
   localparam int RATIO_W     = 10;
   localparam int WINDOW_W    = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   // parameter defaults
   localparam int HISTORY_DEPTH_DEF = 16;
   localparam int RATIO_SCALE_DEF   = 1000;

   // register reset values
   localparam logic [RATIO_W-1:0]  THRESHOLD_RST = 10'd250;
   localparam logic [WINDOW_W-1:0] WINDOW_RST    = 4'd4;
   localparam logic [RATIO_W-1:0]  WEIGHT_RST    = 10'd900;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WINDOW    = 2'd1,
      CSR_WEIGHT    = 2'd2
   } csr_index_type;

   // configuration register set
   typedef struct packed {
      logic [RATIO_W-1:0]  threshold;
      logic [WINDOW_W-1:0] window;
      logic [RATIO_W-1:0]  weight;
   } cfg_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_PREP,
      ST_DIV,
      ST_FIN
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
      logic prep;
      logic div;
      logic finish;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic walk_last;
      logic div_last;
   } dp_status_type;

endpackage

FILE: rtl/wbih_channels.sv
// wbih channel interfaces: request, response and register write channels
// depends on wbih_pkg for payload widths

interface wbih_req_if;
   logic                            valid;
   logic                            ready;
   logic [wbih_pkg::RATIO_W-1:0]    activity_ratio;
   logic                            advance;

   modport source (output valid, output activity_ratio, output advance, input ready);
   modport sink   (input valid, input activity_ratio, input advance, output ready);
endinterface

interface wbih_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            busy_res;
   logic [wbih_pkg::RATIO_W-1:0]    norm_ratio;

   modport source (output valid, output busy_res, output norm_ratio, input ready);
   modport sink   (input valid, input busy_res, input norm_ratio, output ready);
endinterface

interface wbih_csr_if;
   logic                               valid;
   logic                               ready;
   logic [wbih_pkg::CSR_INDEX_W-1:0]   index;
   logic [wbih_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/wbih_csr.sv
// wbih_csr: configuration registers written over the register channel
// depends on wbih_pkg and wbih_csr_if

module wbih_csr (
   input  logic              clock,
   input  logic              reset,
   wbih_csr_if.sink          csr_ch,
   output wbih_pkg::cfg_type cfg
);

   wbih_pkg::cfg_type cfg_ff;
   wbih_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            wbih_pkg::CSR_THRESHOLD: begin
               cfg_in.threshold = csr_ch.data[wbih_pkg::RATIO_W-1:0];
            end
            wbih_pkg::CSR_WINDOW: begin
               cfg_in.window = csr_ch.data[wbih_pkg::WINDOW_W-1:0];
            end
            wbih_pkg::CSR_WEIGHT: begin
               cfg_in.weight = csr_ch.data[wbih_pkg::RATIO_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= wbih_pkg::THRESHOLD_RST;
         cfg_ff.window    <= wbih_pkg::WINDOW_RST;
         cfg_ff.weight    <= wbih_pkg::WEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/wbih_ctrl.sv
// wbih_ctrl: sequencer for history walk, normalizing divide and response hand-off
// depends on wbih_pkg; drives the datapath through dp_cmd_type

module wbih_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  wbih_pkg::dp_status_type  status,
   output wbih_pkg::dp_cmd_type     cmd
);

   wbih_pkg::state_type state_ff;
   wbih_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   // output register can take a new response
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wbih_pkg::ST_IDLE: begin
            if (req_valid) state_in = wbih_pkg::ST_MUL;
         end
         wbih_pkg::ST_MUL: begin
            state_in = wbih_pkg::ST_ACC;
         end
         wbih_pkg::ST_ACC: begin
            state_in = status.walk_last ? wbih_pkg::ST_PREP : wbih_pkg::ST_MUL;
         end
         wbih_pkg::ST_PREP: begin
            state_in = wbih_pkg::ST_DIV;
         end
         wbih_pkg::ST_DIV: begin
            if (status.div_last) state_in = wbih_pkg::ST_FIN;
         end
         wbih_pkg::ST_FIN: begin
            if (out_free) state_in = wbih_pkg::ST_IDLE;
         end
         default: begin
            state_in = wbih_pkg::ST_IDLE;
         end
      endcase
   end

   // commands and handshake outputs
   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         wbih_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         wbih_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         wbih_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
         end
         wbih_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
         end
         wbih_pkg::ST_DIV: begin
            cmd.div = 1'b1;
         end
         wbih_pkg::ST_FIN: begin
            cmd.finish = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wbih_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/wbih_dp.sv
// wbih_dp: ratio history memory, weighted accumulation, restoring divider, decision
// depends on wbih_pkg; sequenced by wbih_ctrl

module wbih_dp #(
   parameter int HISTORY_DEPTH = wbih_pkg::HISTORY_DEPTH_DEF,
   parameter int RATIO_SCALE   = wbih_pkg::RATIO_SCALE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wbih_pkg::dp_cmd_type          cmd,
   output wbih_pkg::dp_status_type       status,
   input  wbih_pkg::cfg_type             cfg,
   input  logic [wbih_pkg::RATIO_W-1:0]  req_ratio,
   input  logic                          req_advance,
   output logic                          rsp_busy,
   output logic [wbih_pkg::RATIO_W-1:0]  rsp_ratio
);

   localparam int SCALE_W    = $clog2(RATIO_SCALE + 1);
   localparam int SLOT_W     = $clog2(HISTORY_DEPTH);
   localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
   localparam int ACC_W      = $clog2(RATIO_SCALE * HISTORY_DEPTH + 1);
   localparam int PROD_W     = ACC_W + SCALE_W;
   localparam int BIT_W      = $clog2(SCALE_W);
   localparam int HALF_DEPTH = HISTORY_DEPTH / 2;
   // reciprocal of the scale, exact for every product below 2**PROD_W
   localparam int RECIP_K    = PROD_W + SCALE_W;
   localparam int RECIP_W    = RECIP_K - $clog2(RATIO_SCALE) + 2;
   localparam int QPROD_W    = PROD_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_K) + RATIO_SCALE - 1) / RATIO_SCALE;
   localparam logic [RECIP_W-1:0]  RECIP_M = RECIP_W'(RECIP_FULL);
   localparam logic [SCALE_W-1:0]  SCALE_C = SCALE_W'(RATIO_SCALE);
   localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

   // history memory and per-entry valid bits
   logic [SCALE_W-1:0]       hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hist_valid_ff, hist_valid_in;

   logic [SLOT_W-1:0]   newest_ff, new_slot;
   logic                busy_ff, busy_in;
   logic [SLOT_W-1:0]   walk_ff, walk_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in, target_ff, target_in, eff_win;
   logic [SCALE_W-1:0]  wt_ff, wt_in, thr_ff, thr_in, r_sat;
   logic [ACC_W-1:0]    acc_ff, acc_in, full_ff, full_in;
   logic [PROD_W-1:0]   pacc_ff, pacc_in, pfull_ff, pfull_in;
   logic [SCALE_W-1:0]  rd_ff;
   logic                rd_valid_ff;
   logic [PROD_W-1:0]   rem_ff, rem_in, den_ff, den_in;
   logic [SCALE_W-1:0]  quo_ff, quo_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic                out_busy_ff, out_busy_in;
   logic [wbih_pkg::RATIO_W-1:0] out_ratio_ff, out_ratio_in;
   logic [QPROD_W-1:0]  qa_prod, qf_prod;
   logic [ACC_W-1:0]    qa, qf;
   logic [SCALE_W-1:0]  rd_eff;
   logic                rem_ge;

   // saturated request ratio and target slot
   always_comb begin
      if (req_ratio > wbih_pkg::RATIO_W'(RATIO_SCALE)) r_sat = SCALE_C;
      else r_sat = req_ratio[SCALE_W-1:0];
      if (!req_advance) new_slot = newest_ff;
      else if (newest_ff == LAST_SLOT) new_slot = '0;
      else new_slot = newest_ff + SLOT_W'(1);
   end

   // window length clamped to one..half the history
   always_comb begin
      if (cfg.window == '0) eff_win = CNT_W'(1);
      else if (32'(cfg.window) > HALF_DEPTH) eff_win = CNT_W'(HALF_DEPTH);
      else eff_win = CNT_W'(cfg.window);
   end

   // scale the decayed sums by the reciprocal of the scale
   assign qa_prod = QPROD_W'(pacc_ff) * QPROD_W'(RECIP_M);
   assign qf_prod = QPROD_W'(pfull_ff) * QPROD_W'(RECIP_M);
   assign qa      = qa_prod[RECIP_K +: ACC_W];
   assign qf      = qf_prod[RECIP_K +: ACC_W];
   assign rd_eff  = rd_valid_ff ? rd_ff : '0;
   assign rem_ge  = rem_ff >= den_ff;

   // next values of the walk and divide registers
   always_comb begin
      hist_valid_in = hist_valid_ff;
      walk_in       = walk_ff;
      cnt_in        = cnt_ff;
      target_in     = target_ff;
      wt_in         = wt_ff;
      thr_in        = thr_ff;
      acc_in        = acc_ff;
      full_in       = full_ff;
      pacc_in       = pacc_ff;
      pfull_in      = pfull_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      bit_in        = bit_ff;
      busy_in       = busy_ff;
      out_busy_in   = out_busy_ff;
      out_ratio_in  = out_ratio_ff;

      if (cmd.load) begin
         hist_valid_in[new_slot] = 1'b1;
         walk_in   = new_slot;
         cnt_in    = '0;
         target_in = busy_ff ? (eff_win << 1) : eff_win;
         wt_in     = (cfg.weight > wbih_pkg::RATIO_W'(RATIO_SCALE)) ?
                     SCALE_C : cfg.weight[SCALE_W-1:0];
         thr_in    = (cfg.threshold > wbih_pkg::RATIO_W'(RATIO_SCALE)) ?
                     SCALE_C : cfg.threshold[SCALE_W-1:0];
         acc_in    = '0;
         full_in   = '0;
      end

      if (cmd.mul) begin
         pacc_in  = PROD_W'(acc_ff) * PROD_W'(wt_ff);
         pfull_in = PROD_W'(full_ff) * PROD_W'(wt_ff);
      end

      if (cmd.acc) begin
         acc_in  = ACC_W'(rd_eff) + qa;
         full_in = ACC_W'(SCALE_C) + qf;
         walk_in = (walk_ff == '0) ? LAST_SLOT : walk_ff - SLOT_W'(1);
         cnt_in  = cnt_ff + CNT_W'(1);
      end

      // numerator and aligned divisor for the quotient bits
      if (cmd.prep) begin
         rem_in = PROD_W'(acc_ff) * PROD_W'(SCALE_C);
         den_in = PROD_W'(full_ff) << (SCALE_W - 1);
         quo_in = '0;
         bit_in = BIT_W'(SCALE_W - 1);
      end

      // one quotient bit per cycle
      if (cmd.div) begin
         if (rem_ge) rem_in = rem_ff - den_ff;
         quo_in = {quo_ff[SCALE_W-2:0], rem_ge};
         den_in = den_ff >> 1;
         bit_in = bit_ff - BIT_W'(1);
      end

      // hysteresis decision
      if (cmd.finish) begin
         if (busy_ff) busy_in = !(quo_ff < (thr_ff >> 1));
         else busy_in = quo_ff > thr_ff;
         out_busy_in  = busy_in;
         out_ratio_in = wbih_pkg::RATIO_W'(quo_ff);
      end
   end

   assign status.walk_last = (cnt_ff == target_ff - CNT_W'(1));
   assign status.div_last  = (bit_ff == '0);
   assign rsp_busy         = out_busy_ff;
   assign rsp_ratio        = out_ratio_ff;

   // history memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.load) hist_mem[new_slot] <= r_sat;
      if (cmd.mul) begin
         rd_ff       <= hist_mem[walk_ff];
         rd_valid_ff <= hist_valid_ff[walk_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
         newest_ff     <= '0;
         busy_ff       <= 1'b0;
      end else begin
         hist_valid_ff <= hist_valid_in;
         busy_ff       <= busy_in;
         if (cmd.load) newest_ff <= new_slot;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      walk_ff      <= walk_in;
      cnt_ff       <= cnt_in;
      target_ff    <= target_in;
      wt_ff        <= wt_in;
      thr_ff       <= thr_in;
      acc_ff       <= acc_in;
      full_ff      <= full_in;
      pacc_ff      <= pacc_in;
      pfull_ff     <= pfull_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quo_ff       <= quo_in;
      bit_ff       <= bit_in;
      out_busy_ff  <= out_busy_in;
      out_ratio_ff <= out_ratio_in;
   end

endmodule

FILE: rtl/weighted_busy_idle_hysteresis.sv
// weighted_busy_idle_hysteresis: top level of the busy/idle tracker
// depends on wbih_pkg, wbih_channels, wbih_csr, wbih_ctrl and wbih_dp
//
// usage
//   req_ch carries one request per scheduler period: activity_ratio in
//   thousandths and advance (1 opens a new history entry, 0 rewrites the
//   newest). rsp_ch returns one response per request: busy_res and the
//   norm_ratio behind the decision. csr_ch writes busy_threshold,
//   busy_window and decay_weight; it is always ready and should be used
//   only while no request is in flight.
//   operation: a request walks n history entries, n = clamped window when
//   idle and twice that when busy, each entry in a multiply step and a
//   reciprocal scale and add step; a restoring divide then yields one
//   quotient bit per cycle.
//   req_ch.ready is high only between requests; the response sits in an
//   output register, so the next request is taken while it waits. if the
//   receiver still stalls when the following result is done, the block
//   holds that result until the register frees.
//   reset marks the history entries invalid so they read as zero, clears the newest
//   slot, the busy flag and the response valid and loads the register defaults (250, 4, 900).

module weighted_busy_idle_hysteresis #(
   parameter int HISTORY_DEPTH = wbih_pkg::HISTORY_DEPTH_DEF,
   parameter int RATIO_SCALE   = wbih_pkg::RATIO_SCALE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   wbih_req_if.sink    req_ch,
   wbih_rsp_if.source  rsp_ch,
   wbih_csr_if.sink    csr_ch
);

   wbih_pkg::cfg_type       cfg;
   wbih_pkg::dp_cmd_type    cmd;
   wbih_pkg::dp_status_type status;

   // configuration registers
   wbih_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // sequencer
   wbih_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // history and arithmetic
   wbih_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .RATIO_SCALE   (RATIO_SCALE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .cfg         (cfg),
      .req_ratio   (req_ch.activity_ratio),
      .req_advance (req_ch.advance),
      .rsp_busy    (rsp_ch.busy_res),
      .rsp_ratio   (rsp_ch.norm_ratio)
   );

   // one request in flight at a time
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while another is in flight");

   // the normalized ratio never exceeds the scale
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.norm_ratio <= wbih_pkg::RATIO_W'(RATIO_SCALE))
      else $error("normalized ratio above scale");

   // the sequencer issues at most one datapath command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("overlapping datapath commands");

   // a finished request always shows up on the response channel
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_ch.valid)
      else $error("finished request not presented");

endmodule

FILE: tb/testbench.sv
// testbench for weighted_busy_idle_hysteresis: directed and random requests, checked
// against an in-bench predictor of the weighted history and the busy/idle hysteresis
// depends on rtl/wbih_pkg.sv, rtl/wbih_channels.sv and the rtl of the block

`timescale 1ns / 100ps

module testbench;

   localparam int RING_DEPTH = wbih_pkg::HISTORY_DEPTH_DEF;
   localparam int SCALE      = wbih_pkg::RATIO_SCALE_DEF;
   localparam int MAX_SHOWN  = 10;
   // index with no register behind it, writes to it are dropped
   localparam logic [wbih_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                         busy;
      logic [wbih_pkg::RATIO_W-1:0] ratio;
   } decision_type;

   logic clock = 1'b0;
   logic reset;

   wbih_req_if req_ch ();
   wbih_rsp_if rsp_ch ();
   wbih_csr_if csr_ch ();

   weighted_busy_idle_hysteresis i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predicted register and history state
   logic [wbih_pkg::RATIO_W-1:0]  cfg_threshold;
   logic [wbih_pkg::WINDOW_W-1:0] cfg_window;
   logic [wbih_pkg::RATIO_W-1:0]  cfg_weight;
   logic [wbih_pkg::RATIO_W-1:0]  ratio_ring [RING_DEPTH];
   int unsigned                   ring_head;
   logic                          tracked_busy;

   decision_type expected_decisions [$];
   decision_type oldest_decision;
   int           failures;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           run_left;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // saturate a value to the ratio scale
   function automatic int unsigned clamp_scale(input int unsigned v);
      return (v > SCALE) ? SCALE : v;
   endfunction

   // normalized weighted sum over the newest count entries
   function automatic int unsigned weighted_history(input int unsigned count);
      longint unsigned acc;
      longint unsigned full;
      longint unsigned wt;
      int unsigned     slot;
      acc  = 0;
      full = 0;
      wt   = clamp_scale(cfg_weight);
      slot = ring_head;
      for (int i = 0; i < count; i++) begin
         acc  = ratio_ring[slot] + (acc * wt) / SCALE;
         full = SCALE + (full * wt) / SCALE;
         slot = (slot == 0) ? RING_DEPTH - 1 : slot - 1;
      end
      if (full == 0) return 0;
      return int'((acc * SCALE) / full);
   endfunction

   // update the history with one request and work out the decision it yields
   function automatic decision_type predict_decision(
         input logic [wbih_pkg::RATIO_W-1:0] ratio_in,
         input logic adv);
      int unsigned  thr;
      int unsigned  win;
      int unsigned  ratio;
      decision_type d;
      thr = clamp_scale(cfg_threshold);
      win = cfg_window;
      if (win < 1) win = 1;
      if (win > RING_DEPTH / 2) win = RING_DEPTH / 2;
      if (adv) ring_head = (ring_head + 1) % RING_DEPTH;
      ratio_ring[ring_head] = wbih_pkg::RATIO_W'(clamp_scale(ratio_in));
      if (tracked_busy) begin
         ratio = weighted_history(win * 2);
         if (ratio < (thr >> 1)) tracked_busy = 1'b0;
      end else begin
         ratio = weighted_history(win);
         if (ratio > thr) tracked_busy = 1'b1;
      end
      d.busy  = tracked_busy;
      d.ratio = ratio[wbih_pkg::RATIO_W-1:0];
      return d;
   endfunction

   // send one request after an optional random gap, then record what it should yield
   task automatic send_request(input logic [wbih_pkg::RATIO_W-1:0] ratio_in,
                               input logic adv);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.activity_ratio <= ratio_in;
      req_ch.advance        <= adv;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      expected_decisions.push_back(predict_decision(ratio_in, adv));
   endtask

   // stop sending and wait until every expected response has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_decisions.size() != 0);
   endtask

   // one register write, only issued while the block is idle
   task automatic write_register(input logic [wbih_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [wbih_pkg::CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      case (idx)
         wbih_pkg::CSR_THRESHOLD: cfg_threshold = value;
         wbih_pkg::CSR_WINDOW:    cfg_window    = value[wbih_pkg::WINDOW_W-1:0];
         wbih_pkg::CSR_WEIGHT:    cfg_weight    = value;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         run_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_decisions.size() == 0) begin
               failures++;
               if (failures <= MAX_SHOWN)
                  $display("unexpected response: busy %0d ratio %0d",
                           rsp_ch.busy_res, rsp_ch.norm_ratio);
            end else begin
               oldest_decision = expected_decisions.pop_front();
               if (oldest_decision.busy !== rsp_ch.busy_res ||
                   oldest_decision.ratio !== rsp_ch.norm_ratio) begin
                  failures++;
                  if (failures <= MAX_SHOWN)
                     $display("mismatch at %0t: busy exp %0d got %0d, ratio exp %0d got %0d",
                              $realtime, oldest_decision.busy, rsp_ch.busy_res,
                              oldest_decision.ratio, rsp_ch.norm_ratio);
               end
            end
         end
         // ready and stall come in runs of random length so that held results are exercised
         if (run_left > 0) begin
            run_left--;
         end else begin
            run_left = $urandom_range(0, 19);
            rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // defaults after reset, saturating ratio, overwrite of the newest entry, going busy
   task automatic test_reset_defaults();
      send_request(10'd0, 1'b0);
      send_request(10'd1023, 1'b0);
      send_request(10'd1000, 1'b1);
      send_request(10'd1000, 1'b1);
      send_request(10'd0, 1'b0);
      send_request(10'd0, 1'b1);
      send_request(10'd0, 1'b1);
      send_request(10'd0, 1'b1);
      wait_drained();
   endtask

   // register extremes: zero and saturating threshold, window and weight
   task automatic test_register_extremes();
      write_register(wbih_pkg::CSR_THRESHOLD, 10'd0);
      write_register(wbih_pkg::CSR_WINDOW, 10'd0);
      write_register(wbih_pkg::CSR_WEIGHT, 10'd0);
      send_request(10'd1, 1'b1);
      send_request(10'd0, 1'b1);
      send_request(10'd0, 1'b0);
      wait_drained();
      write_register(wbih_pkg::CSR_THRESHOLD, 10'd1023);
      write_register(wbih_pkg::CSR_WINDOW, 10'd15);
      write_register(wbih_pkg::CSR_WEIGHT, 10'd1023);
      send_request(10'd1000, 1'b1);
      send_request(10'd1023, 1'b1);
      send_request(10'd512, 1'b0);
      wait_drained();
      // unused index must leave every register alone
      write_register(CSR_UNUSED, 10'd1023);
      send_request(10'd511, 1'b1);
      wait_drained();
      write_register(wbih_pkg::CSR_THRESHOLD, 10'd1000);
      write_register(wbih_pkg::CSR_WINDOW, 10'd8);
      write_register(wbih_pkg::CSR_WEIGHT, 10'd1000);
      send_request(10'd1000, 1'b1);
      send_request(10'd0, 1'b1);
      wait_drained();
      write_register(wbih_pkg::CSR_WINDOW, 10'd9);
      write_register(wbih_pkg::CSR_THRESHOLD, 10'd200);
      send_request(10'd900, 1'b1);
      send_request(10'd900, 1'b1);
      wait_drained();
   endtask

   // random registers, then bursts of ratios around a level to swing busy and idle
   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      int                           level;
      int                           burst;
      int                           value;
      logic [wbih_pkg::RATIO_W-1:0] ratio_in;
      wait_drained();
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      case ($urandom_range(9))
         0:       write_register(wbih_pkg::CSR_THRESHOLD, 10'd0);
         1:       write_register(wbih_pkg::CSR_THRESHOLD, 10'd1023);
         2:       write_register(wbih_pkg::CSR_THRESHOLD, 10'd1000);
         default: write_register(wbih_pkg::CSR_THRESHOLD,
                                 wbih_pkg::CSR_DATA_W'($urandom_range(50, 600)));
      endcase
      write_register(wbih_pkg::CSR_WINDOW, wbih_pkg::CSR_DATA_W'($urandom_range(0, 1023)));
      case ($urandom_range(9))
         0:       write_register(wbih_pkg::CSR_WEIGHT, 10'd0);
         1:       write_register(wbih_pkg::CSR_WEIGHT, 10'd1023);
         default: write_register(wbih_pkg::CSR_WEIGHT,
                                 wbih_pkg::CSR_DATA_W'($urandom_range(500, 1000)));
      endcase
      burst = 0;
      level = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            case ($urandom_range(3))
               0:       level = $urandom_range(0, 100);
               1:       level = $urandom_range(800, 1000);
               default: level = clamp_scale(cfg_threshold) + $urandom_range(0, 200) - 100;
            endcase
         end
         burst--;
         value = level + $urandom_range(0, 100) - 50;
         if (value < 0) value = 0;
         if (value > SCALE) value = SCALE;
         // some noise across the whole field, saturating values included
         if ($urandom_range(9) == 0) value = $urandom_range(0, 1023);
         ratio_in = value[wbih_pkg::RATIO_W-1:0];
         send_request(ratio_in, $urandom_range(3) != 0);
         // midway: let everything come back before going on
         if (n == count / 2) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.activity_ratio <= '0;
      req_ch.advance        <= 1'b0;
      csr_ch.valid          <= 1'b0;
      csr_ch.index          <= wbih_pkg::CSR_THRESHOLD;
      csr_ch.data           <= '0;
      failures       = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      cfg_threshold  = wbih_pkg::THRESHOLD_RST;
      cfg_window     = wbih_pkg::WINDOW_RST;
      cfg_weight     = wbih_pkg::WEIGHT_RST;
      ring_head      = 0;
      tracked_busy   = 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) ratio_ring[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_random_traffic(160, 0, 0);
      test_random_traffic(160, 0, 0);
      test_random_traffic(160, 60, 0);
      test_random_traffic(160, 60, 0);
      test_random_traffic(160, 0, 60);
      test_random_traffic(160, 0, 60);
      test_random_traffic(160, 24, 24);
      test_random_traffic(160, 24, 24);

      // quiet tail to catch stray responses
      repeat (60) @(posedge clock);
      if (expected_decisions.size() != 0)
         $display("%0d responses never arrived", expected_decisions.size());
      if (failures == 0 && expected_decisions.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", expected_decisions.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
rtl/wbih_pkg.sv
rtl/wbih_channels.sv
rtl/wbih_csr.sv
rtl/wbih_ctrl.sv
rtl/wbih_dp.sv
rtl/weighted_busy_idle_hysteresis.sv
tb/testbench.sv
